### src/sha1_digest_16byte_truncated_core_assert.svh
// Assertion macros for the truncated SHA-1 core checker.
// Depends on nothing; included by the checker file only.
`ifndef SHA1_DIGEST_16BYTE_TRUNCATED_CORE_ASSERT_SVH
`define SHA1_DIGEST_16BYTE_TRUNCATED_CORE_ASSERT_SVH

// same-cycle implication
`define SHA1DT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1DT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sha1dt_pkg.sv
// Shared constants, types and round functions for the truncated SHA-1 core.
// No dependencies.
`default_nettype none

package sha1dt_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned WinWords  = 16;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] IV_E = 32'hC3D2E1F0;

  localparam logic [31:0] RC_0 = 32'h5A827999;
  localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] LEN_BITS = 32'h00000080;

  typedef logic [WinWords-1:0][31:0] sha1dt_win_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    sha1dt_win_t win;   // win[0] is the word for the current round
  } sha1dt_state_t;

  function automatic logic [31:0] rol1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rol5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

  function automatic logic [31:0] round_f(input int unsigned idx, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (idx < 20) begin
      res = d ^ (b & (c ^ d));
    end else if (idx < 40) begin
      res = b ^ c ^ d;
    end else if (idx < 60) begin
      res = (b & c) | (d & (b | c));
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_k(input int unsigned idx);
    logic [31:0] res;
    if (idx < 20) begin
      res = RC_0;
    end else if (idx < 40) begin
      res = RC_1;
    end else if (idx < 60) begin
      res = RC_2;
    end else begin
      res = RC_3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/sha1dt_round.sv
// One SHA-1 round cell: registered working variables plus a shifting schedule window.
// Depends on sha1dt_pkg.
`default_nettype none

module sha1dt_round
  import sha1dt_pkg::*;
#(
  parameter int unsigned ROUND_IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          prev_valid,
  input  wire sha1dt_state_t prev_state,
  output logic               cur_valid,
  output sha1dt_state_t      cur_state
);

  logic          valid_r;
  logic          valid_nxt;
  sha1dt_state_t state_r;
  sha1dt_state_t state_nxt;
  logic [31:0]   w_new;

  always_comb begin
    w_new = rol1(prev_state.win[13] ^ prev_state.win[8] ^ prev_state.win[2] ^
                 prev_state.win[0]);
    state_nxt.a = rol5(prev_state.a)
                + round_f(ROUND_IDX, prev_state.b, prev_state.c, prev_state.d)
                + prev_state.e + round_k(ROUND_IDX) + prev_state.win[0];
    state_nxt.b = prev_state.a;
    state_nxt.c = rol30(prev_state.b);
    state_nxt.d = prev_state.c;
    state_nxt.e = prev_state.d;
    for (int i = 0; i < WinWords - 1; i++) begin
      state_nxt.win[i] = prev_state.win[i+1];
    end
    state_nxt.win[WinWords-1] = w_new;
    valid_nxt = en ? prev_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
    end
  end

  assign cur_valid = valid_r;
  assign cur_state = state_r;

endmodule

`default_nettype wire

### src/sha1dt_outbuf.sv
// Output stage: final feed-forward add, output register and skid register.
// Depends on sha1dt_pkg.
`default_nettype none

module sha1dt_outbuf
  import sha1dt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  input  wire sha1dt_state_t up_state,
  output logic               up_ready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [127:0]       out_tdata
);

  logic [127:0] dig;
  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;
  logic [127:0] skid_data_r, skid_data_nxt;
  logic         take_up;

  // {C,D} above {A,B}: digest_hi in the low 64 bits
  assign dig = {up_state.c + IV_C, up_state.d + IV_D,
                up_state.a + IV_A, up_state.b + IV_B};

  assign up_ready = !skid_valid_r;
  assign take_up  = up_valid && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_tready) begin
      if (take_up) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = dig;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = take_up;
      out_data_nxt  = dig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### src/sha1_digest_16byte_truncated_core.sv
// Top level of the truncated SHA-1 core: 80 round cells in a row and the output stage.
// Depends on sha1dt_pkg, sha1dt_round and sha1dt_outbuf.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata, each a 16-byte message
//   (msg_hi in bits 63:0, msg_lo in bits 127:64, big-endian bytes). Each word
//   yields one result word on out_tvalid/out_tready/out_tdata: the first four
//   SHA-1 digest words, digest_hi = {A,B} in bits 63:0, digest_lo = {C,D} above.
//   With no stall, an accepted word passes the 80 round cells and then the
//   output register before it shows on out_tvalid.
//   Throughput: one word per cycle while in_tready is high; each round has its
//   own cell, so a new message can enter while earlier ones move down the row.
//   Stall: when the receiver holds out_tready low, one more result lands in a
//   skid register; then in_tready drops and the whole row of cells freezes
//   until the output drains. in_tready comes from a register only.
//   Reset: rst_n low synchronously clears all valid flags; in-flight words
//   are dropped. in_tready is high in the first cycle after reset.
`default_nettype none

module sha1_digest_16byte_truncated_core
  import sha1dt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // msg_hi [63:0], msg_lo [127:64]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // digest_hi [63:0], digest_lo [127:64]
);

  logic          adv;
  sha1dt_state_t init_state;
  logic          cell_valid [NumRounds+1];
  sha1dt_state_t cell_state [NumRounds+1];

  always_comb begin
    init_state.a = IV_A;
    init_state.b = IV_B;
    init_state.c = IV_C;
    init_state.d = IV_D;
    init_state.e = IV_E;
    for (int i = 0; i < WinWords; i++) begin
      init_state.win[i] = '0;
    end
    init_state.win[0]          = in_tdata[63:32];
    init_state.win[1]          = in_tdata[31:0];
    init_state.win[2]          = in_tdata[127:96];
    init_state.win[3]          = in_tdata[95:64];
    init_state.win[4]          = PAD_WORD;
    init_state.win[WinWords-1] = LEN_BITS;
  end

  assign in_tready     = adv;
  assign cell_valid[0] = in_tvalid;
  assign cell_state[0] = init_state;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    sha1dt_round #(
      .ROUND_IDX (g)
    ) u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .prev_valid (cell_valid[g]),
      .prev_state (cell_state[g]),
      .cur_valid  (cell_valid[g+1]),
      .cur_state  (cell_state[g+1])
    );
  end

  sha1dt_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (cell_valid[NumRounds]),
    .up_state   (cell_state[NumRounds]),
    .up_ready   (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### src/sha1dt_checker.sv
// Port-level checker for the truncated SHA-1 core, bound to the top level.
// Depends on sha1_digest_16byte_truncated_core_assert.svh.
`default_nettype none
`include "sha1_digest_16byte_truncated_core_assert.svh"

module sha1dt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  `SHA1DT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")
  `SHA1DT_ASSERT_IMPLY(a_full_has_out, clk, rst_n, !in_tready, out_tvalid, "input blocked with empty output")
  `SHA1DT_ASSERT_IMPLY(a_block_cause, clk, rst_n, !in_tready, $past(out_tvalid && !out_tready), "input blocked without output stall")

endmodule

bind sha1_digest_16byte_truncated_core sha1dt_checker u_sha1dt_checker (.*);

`default_nettype wire
